@@ design/last_argument_locator_top_macros.svh @@
// assertion macros for the last argument locator checker
`ifndef LAST_ARGUMENT_LOCATOR_TOP_MACROS_SVH
`define LAST_ARGUMENT_LOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("last_argument_locator: same-cycle check failed");

// next-cycle implication, disabled in reset
`define LAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("last_argument_locator: next-cycle check failed");

`endif

@@ design/lal_pkg.sv @@
// shared constants, types and helpers for the last argument locator
package lal_pkg;

    localparam int LINE_MAX = 256;
    localparam int POS_W    = $clog2(LINE_MAX);
    localparam int ARG_W    = 8;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [2:0]       t_cls;

    // character classes
    localparam t_cls CLS_END   = 3'd0;
    localparam t_cls CLS_SEP   = 3'd1;
    localparam t_cls CLS_DQ    = 3'd2;
    localparam t_cls CLS_SQ    = 3'd3;
    localparam t_cls CLS_GT    = 3'd4;
    localparam t_cls CLS_LTP   = 3'd5;
    localparam t_cls CLS_OTHER = 3'd6;

    // low bits of a position as reported on the result
    function automatic logic [ARG_W-1:0] to_arg(input t_pos p);
        logic [31:0] w;
        w = 32'(p);
        return w[ARG_W-1:0];
    endfunction

endpackage

@@ design/last_argument_locator_top.sv @@
// top level of the last argument locator
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+--------------------------
//   input   | i_in_valid  | o_in_ready  | i_ch
//   result  | o_out_valid | i_out_ready | o_arg_start, o_open_quote
//
// one character is taken per cycle while o_in_ready is high; the state machine
// in the back end handles one class per cycle unless a stalled result holds it,
// and a zero byte passes through the queue before its result is registered
// reset is synchronous; a two-entry queue sits between front and back, so input
// flows while a result waits; o_in_ready drops on a full queue or low r_seen
module last_argument_locator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_ch,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lal_pkg::ARG_W-1:0]   o_arg_start,
    output logic                        o_open_quote
);
    import lal_pkg::*;

    logic f_valid, f_ready;
    t_cls f_cls;
    logic b_valid, b_ready;
    t_cls b_cls;

    lal_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .o_cls_valid (f_valid),
        .i_cls_ready (f_ready),
        .o_cls       (f_cls)
    );

    lal_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cls   (f_cls),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_cls    (b_cls)
    );

    lal_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cls_valid  (b_valid),
        .o_cls_ready  (b_ready),
        .i_cls        (b_cls),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_arg_start  (o_arg_start),
        .o_open_quote (o_open_quote)
    );
endmodule

@@ design/lal_front.sv @@
// front end: takes characters and reduces them to token classes
module lal_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_ch,
    output logic            o_cls_valid,
    input  logic            i_cls_ready,
    output lal_pkg::t_cls   o_cls
);
    import lal_pkg::*;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_PIPE = 8'h7C;

    logic r_seen;

    always_comb begin
        case (i_ch)
            CH_NUL:          o_cls = CLS_END;
            CH_TAB, CH_SP:   o_cls = CLS_SEP;
            CH_DQ:           o_cls = CLS_DQ;
            CH_SQ:           o_cls = CLS_SQ;
            CH_GT:           o_cls = CLS_GT;
            CH_LT, CH_PIPE:  o_cls = CLS_LTP;
            default:         o_cls = CLS_OTHER;
        endcase
    end

    assign o_cls_valid = i_in_valid && r_seen;
    assign o_in_ready  = i_cls_ready && r_seen;

    // holds off input after reset until r_seen is set, so the queue is settled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end
endmodule

@@ design/lal_queue.sv @@
// two-entry class queue between front and back
module lal_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  lal_pkg::t_cls   i_push_cls,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output lal_pkg::t_cls   o_pop_cls
);
    import lal_pkg::*;

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cls    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end
endmodule

@@ design/lal_back.sv @@
// back end: tokenizer state machine and result register
module lal_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cls_valid,
    output logic                        o_cls_ready,
    input  lal_pkg::t_cls               i_cls,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lal_pkg::ARG_W-1:0]   o_arg_start,
    output logic                        o_open_quote
);
    import lal_pkg::*;

    localparam logic [1:0] MODE_SKIP  = 2'd0;
    localparam logic [1:0] MODE_WORD  = 2'd1;
    localparam logic [1:0] MODE_QUOTE = 2'd2;
    localparam logic [1:0] MODE_GT    = 2'd3;

    localparam t_pos POS_MAX = POS_W'(LINE_MAX - 1);

    logic [1:0]       r_mode, n_mode;
    logic             r_qsingle, n_qsingle;
    t_pos             r_pos, n_pos;
    t_pos             r_wstart, n_wstart;
    t_pos             r_qstart, n_qstart;
    logic             r_out_valid, n_out_valid;
    logic [ARG_W-1:0] r_arg, n_arg;
    logic             r_open, n_open;
    logic             take, begin_tok;
    t_pos             pos_inc;

    assign o_cls_ready  = !r_out_valid || i_out_ready;
    assign take         = i_cls_valid && o_cls_ready;
    assign pos_inc      = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_arg_start  = r_arg;
    assign o_open_quote = r_open;

    always_comb begin
        n_mode      = r_mode;
        n_qsingle   = r_qsingle;
        n_pos       = r_pos;
        n_wstart    = r_wstart;
        n_qstart    = r_qstart;
        n_out_valid = r_out_valid && !i_out_ready;
        n_arg       = r_arg;
        n_open      = r_open;
        begin_tok   = 1'b0;
        if (take) begin
            if (i_cls == CLS_END) begin
                n_out_valid = 1'b1;
                n_open      = (r_mode == MODE_QUOTE);
                n_arg       = to_arg((r_mode == MODE_QUOTE) ? r_qstart : r_wstart);
                n_mode      = MODE_SKIP;
                n_qsingle   = 1'b0;
                n_pos       = '0;
                n_wstart    = '0;
                n_qstart    = '0;
            end else begin
                case (r_mode)
                    MODE_QUOTE: begin
                        if ((i_cls == CLS_SQ && r_qsingle) || (i_cls == CLS_DQ && !r_qsingle)) begin
                            n_mode = MODE_SKIP;
                        end
                    end
                    MODE_WORD: begin
                        if (i_cls == CLS_SEP) begin
                            n_mode = MODE_SKIP;
                        end else if (i_cls == CLS_GT || i_cls == CLS_LTP) begin
                            begin_tok = 1'b1;
                        end
                    end
                    MODE_GT: begin
                        if (i_cls == CLS_GT || i_cls == CLS_SEP) begin
                            n_mode = MODE_SKIP;
                        end else begin
                            begin_tok = 1'b1;
                        end
                    end
                    default: begin
                        if (i_cls != CLS_SEP) begin
                            begin_tok = 1'b1;
                        end
                    end
                endcase
                if (begin_tok) begin
                    n_wstart = r_pos;
                    case (i_cls)
                        CLS_DQ, CLS_SQ: begin
                            n_mode    = MODE_QUOTE;
                            n_qsingle = (i_cls == CLS_SQ);
                            n_qstart  = pos_inc;
                        end
                        CLS_GT:  n_mode = MODE_GT;
                        CLS_LTP: n_mode = MODE_SKIP;
                        default: n_mode = MODE_WORD;
                    endcase
                end
                n_pos = pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_arg  <= n_arg;
        r_open <= n_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SKIP;
            r_qsingle   <= 1'b0;
            r_pos       <= '0;
            r_wstart    <= '0;
            r_qstart    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_qsingle   <= n_qsingle;
            r_pos       <= n_pos;
            r_wstart    <= n_wstart;
            r_qstart    <= n_qstart;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

@@ design/lal_checker.sv @@
// port-level checks for the last argument locator, bound to the top level
`include "last_argument_locator_top_macros.svh"

module lal_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [lal_pkg::ARG_W-1:0]   o_arg_start,
    input  logic                        o_open_quote
);
    import lal_pkg::*;

    logic           in_take;
    logic           idle_take;
    logic           out_stall;
    logic [ARG_W:0] out_data;

    assign in_take   = i_in_valid && o_in_ready;
    assign idle_take = in_take && !o_out_valid;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_data  = {o_arg_start, o_open_quote};

    // a stalled result holds
    `LAL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_data))

    // no result straight out of reset
    `LAL_ASSERT_NOW(a_no_out_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

    // a result never appears the cycle after the first accepted item of a clean start
    `LAL_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n, idle_take && $past(!i_rst_n), !o_out_valid)

    // the queue is empty after reset, so input opens up once r_seen is set
    `LAL_ASSERT_NEXT(a_ready_after_reset, i_clk, i_rst_n, $past(!i_rst_n), o_in_ready)
endmodule

bind last_argument_locator_top lal_checker u_lal_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_arg_start  (o_arg_start),
    .o_open_quote (o_open_quote)
);

@@ tb/tb_top.sv @@
// testbench for the last argument locator: directed and random command lines against a predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 2000;

    // character codes the tokenizer reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    typedef enum logic [1:0] {TK_SKIP, TK_WORD, TK_QUOTE, TK_GT} t_tok_mode;

    typedef struct packed {
        logic [lal_pkg::ARG_W-1:0] arg_start;
        logic                      open_quote;
    } t_arg_result;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_ready;
    logic [7:0]                i_ch         = 8'h00;
    logic                      o_out_valid;
    logic                      i_out_ready  = 1'b0;
    logic [lal_pkg::ARG_W-1:0] o_arg_start;
    logic                      o_open_quote;

    // tokenizer state tracked by the predictor
    t_tok_mode tok_mode    = TK_SKIP;
    logic      tok_single  = 1'b0;
    int        cur_pos     = 0;
    int        tok_start   = 0;
    int        quote_after = 0;

    t_arg_result arg_expect_q[$];
    logic [7:0]  line_q[$];

    int send_idle_pct   = 29;
    int recv_idle_pct   = 52;
    int cycle_count     = 0;
    int err_count       = 0;
    int chars_sent      = 0;
    int lines_sent      = 0;
    int results_checked = 0;
    int open_quotes     = 0;

    last_argument_locator_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_arg_start  (o_arg_start),
        .o_open_quote (o_open_quote)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clamp_pos(input int p);
        return (p >= lal_pkg::LINE_MAX - 1) ? lal_pkg::LINE_MAX - 1 : p;
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_special(input logic [7:0] c);
        return is_sep(c) || c == CH_DQ || c == CH_SQ || c == CH_GT || c == CH_LT
            || c == CH_PIPE || c == CH_NUL;
    endfunction

    task automatic open_token(input logic [7:0] c, input int p);
        tok_start = p;
        if (c == CH_DQ || c == CH_SQ) begin
            tok_mode    = TK_QUOTE;
            tok_single  = (c == CH_SQ);
            quote_after = clamp_pos(p + 1);
        end else if (c == CH_GT) begin
            tok_mode = TK_GT;
        end else if (c == CH_LT || c == CH_PIPE) begin
            tok_mode = TK_SKIP;
        end else begin
            tok_mode = TK_WORD;
        end
    endtask

    // advance the tokenizer by one character, queue the result on the zero byte
    task automatic track_last_arg(input logic [7:0] c);
        t_arg_result r;
        int p;
        p = cur_pos;
        if (c == CH_NUL) begin
            if (tok_mode == TK_QUOTE) begin
                r.arg_start  = lal_pkg::ARG_W'(quote_after);
                r.open_quote = 1'b1;
            end else begin
                r.arg_start  = lal_pkg::ARG_W'(tok_start);
                r.open_quote = 1'b0;
            end
            arg_expect_q.push_back(r);
            lines_sent++;
            tok_mode    = TK_SKIP;
            tok_single  = 1'b0;
            cur_pos     = 0;
            tok_start   = 0;
            quote_after = 0;
        end else begin
            case (tok_mode)
                TK_QUOTE: begin
                    if (c == (tok_single ? CH_SQ : CH_DQ))
                        tok_mode = TK_SKIP;
                end
                TK_WORD: begin
                    if (is_sep(c))
                        tok_mode = TK_SKIP;
                    else if (c == CH_GT || c == CH_LT || c == CH_PIPE)
                        open_token(c, p);
                end
                TK_GT: begin
                    if (c == CH_GT || is_sep(c))
                        tok_mode = TK_SKIP;
                    else
                        open_token(c, p);
                end
                default: begin
                    if (!is_sep(c))
                        open_token(c, p);
                end
            endcase
            cur_pos = clamp_pos(p + 1);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // called in the time step of a rising edge; returns in the step the item is taken
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_ch       <= 8'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        chars_sent++;
        track_last_arg(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_line_q();
        foreach (line_q[i])
            send_char(line_q[i]);
    endtask

    // hold the input off until every expected result has come back or DRAIN_LIMIT runs out
    task automatic wait_results_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (arg_expect_q.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_special(c));
        return c;
    endfunction

    function automatic logic [7:0] quoted_char(input logic [7:0] q);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == q);
        return c;
    endfunction

    task automatic push_seps(input int n);
        repeat (n) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic push_quote(input logic [7:0] q, input bit closed);
        line_q.push_back(q);
        repeat ($urandom_range(0, 4)) line_q.push_back(quoted_char(q));
        if (closed)
            line_q.push_back(q);
    endtask

    task automatic push_token();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: repeat ($urandom_range(1, 5)) line_q.push_back(word_char());
            4: push_quote(CH_SQ, 1'b1);
            5: push_quote(CH_DQ, 1'b1);
            6: line_q.push_back(CH_GT);
            7: begin
                line_q.push_back(CH_GT);
                line_q.push_back(CH_GT);
            end
            8: line_q.push_back(CH_LT);
            default: line_q.push_back(CH_PIPE);
        endcase
    endtask

    // words and separators only, so it never opens a quote or a redirection
    task automatic push_filler(input int n);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                push_seps(1);
            else
                line_q.push_back(word_char());
        end
    endtask

    task automatic build_random_line();
        int ntok;
        line_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise: any nonzero bytes
            repeat ($urandom_range(0, 20)) line_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            ntok = $urandom_range(0, 6);
            if ($urandom_range(0, 2) == 0)
                push_seps($urandom_range(1, 3));
            for (int i = 0; i < ntok; i++) begin
                // tokens sometimes touch, so delimiters get exercised without separators
                if (i > 0 && $urandom_range(0, 4) != 0)
                    push_seps($urandom_range(1, 3));
                push_token();
            end
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_seps(1);
                push_quote($urandom_range(0, 1) ? CH_SQ : CH_DQ, 1'b0);
            end
            if ($urandom_range(0, 2) == 0)
                push_seps($urandom_range(1, 3));
        end
        line_q.push_back(CH_NUL);
    endtask

    always @(posedge i_clk) begin : result_check
        t_arg_result want;
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (arg_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected, arg_start", o_arg_start, 0);
            end else begin
                want = arg_expect_q.pop_front();
                results_checked++;
                if (want.open_quote)
                    open_quotes++;
                if (o_arg_start !== want.arg_start)
                    report_mismatch("arg_start", o_arg_start, want.arg_start);
                if (o_open_quote !== want.open_quote)
                    report_mismatch("open_quote", o_open_quote, want.open_quote);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic test_directed();
        send_char(CH_NUL);                  // empty line
        send_text(" \t");                   // separators only
        send_char(CH_NUL);
        send_char(8'hFF);                   // top bits set, trailing separator
        send_char(8'h80);
        send_char(CH_SPACE);
        send_char(CH_NUL);
        send_text("a>>b");                  // double redirection completes its token
        send_char(CH_NUL);
        send_text(">c");                    // character after a single > starts a token
        send_char(CH_NUL);
        send_text("<|");
        send_char(CH_NUL);
        send_text("'a\"'");                 // closed single quote holding a double quote
        send_char(CH_NUL);
        send_text("\"x");                   // line ends inside a double quote
        send_char(CH_NUL);
    endtask

    task automatic test_random_lines(input int snd_pct, input int rcv_pct, input int n_chars);
        int start;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            build_random_line();
            send_line_q();
        end
    endtask

    // lines that run past the point where the position counter saturates
    task automatic test_long_lines();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        line_q.delete();
        push_filler(253);
        push_seps(1);
        push_quote(CH_SQ, 1'b0);            // quote opened at the last unsaturated index
        line_q.push_back(CH_NUL);
        send_line_q();
        line_q.delete();
        push_filler(299);
        push_seps(1);
        line_q.push_back(word_char());
        line_q.push_back(CH_NUL);
        send_line_q();
        line_q.delete();
        push_filler(269);
        push_seps(1);
        push_quote(CH_DQ, 1'b0);
        line_q.push_back(CH_NUL);
        send_line_q();
    endtask

    initial begin : run
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_lines(29, 52, 370);
        wait_results_drained();
        test_random_lines(52, 29, 370);
        test_long_lines();
        test_random_lines(0, 0, 370);
        wait_results_drained();
        if (arg_expect_q.size() != 0)
            report_mismatch("results never delivered, count", 0, arg_expect_q.size());
        repeat (8) @(posedge i_clk);
        $display("run covered %0d lines, %0d characters, %0d results (%0d with an open quote)",
                 lines_sent, chars_sent, results_checked, open_quotes);
        $display("idle mixes 29/52, 52/29 and none; lines up to 302 characters");
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ last_argument_locator_top.f @@
+incdir+design
design/lal_pkg.sv
design/lal_front.sv
design/lal_queue.sv
design/lal_back.sv
design/last_argument_locator_top.sv
design/lal_checker.sv
tb/tb_top.sv
